/* rtl/core/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Shared sizes, select codes and bundles of the tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int NOTE_SLOTS = 32;
  localparam int POS_W      = $clog2(NOTE_SLOTS);
  // read addresses carry one extra bit so a look-ahead past the last slot is visible
  localparam int ADDR_W     = POS_W + 1;

  localparam int SLOT_W = 5;
  localparam int DUR_W  = 8;
  localparam int FREQ_W = 16;

  // next value of the current-slot window register
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_MEM,
    CUR_NXT,
    CUR_DEC,
    CUR_ZERO
  } cur_sel_e;

  // next value of the look-ahead window register
  typedef enum logic [1:0] {
    NXT_HOLD,
    NXT_MEM,
    NXT_ZERO
  } nxt_sel_e;

  typedef struct packed {
    logic              wr_en;
    logic              wr_freq_en;
    logic [POS_W-1:0]  wr_addr;
    logic [DUR_W-1:0]  wr_dur;
    logic [FREQ_W-1:0] wr_freq;
    cur_sel_e          cur_sel;
    logic [ADDR_W-1:0] cur_addr;
    nxt_sel_e          nxt_sel;
    logic [ADDR_W-1:0] nxt_addr;
  } store_ctrl_t;

  typedef struct packed {
    logic              speaker_on;
    logic [FREQ_W-1:0] tone_frequency;
    logic [SLOT_W-1:0] play_position;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/tick_driven_tone_sequencer.sv */
// ----------------------------------------------------------------------------
// tick_driven_tone_sequencer
// Melody sequencer: note writes and timer ticks in, speaker state out.
// ----------------------------------------------------------------------------
// One item per clock, one result per item, delivered in the cycle after the
// transfer through a single result register; input stall follows output
// stall while that register holds an untaken result. The current slot and
// the slot after it are kept in window registers loaded from the note
// memory, so each item needs at most one memory write and two reads: the
// look-ahead read while playing, or slots 0 and 1 on the rewind of a write.
// Durations come out of reset as zero through per-slot valid bits; there is
// no clearing pass. Frequencies of unwritten slots are undefined.
`default_nettype none

module tick_driven_tone_sequencer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        action_i,
  input  wire logic [tts_pkg::SLOT_W-1:0]  slot_i,
  input  wire logic [tts_pkg::DUR_W-1:0]   note_duration_i,
  input  wire logic [tts_pkg::FREQ_W-1:0]  note_frequency_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             speaker_on_o,
  output logic [tts_pkg::FREQ_W-1:0]       tone_frequency_o,
  output logic [tts_pkg::SLOT_W-1:0]       play_position_o
);
  import tts_pkg::*;

  logic             sound_enable_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             playing_q, playing_d;

  logic              accept;
  logic              slot_in_range, at_last, advance;
  logic [DUR_W-1:0]  cur_dur, nxt_dur, dec_dur;
  logic [FREQ_W-1:0] cur_freq, nxt_freq;
  store_ctrl_t       ctrl;
  result_t           res_d, res_q;

  assign accept        = in_valid_i && !in_stall_o;
  assign slot_in_range = int'(slot_i) < NOTE_SLOTS;
  assign at_last       = pos_q == POS_W'(NOTE_SLOTS - 1);
  assign dec_dur       = cur_dur - DUR_W'(1);

  always_comb begin
    ctrl.wr_en      = 1'b0;
    ctrl.wr_freq_en = 1'b0;
    ctrl.wr_addr    = pos_q;
    ctrl.wr_dur     = dec_dur;
    ctrl.wr_freq    = note_frequency_i;
    ctrl.cur_sel    = CUR_HOLD;
    ctrl.cur_addr   = '0;
    ctrl.nxt_sel    = NXT_HOLD;
    ctrl.nxt_addr   = ADDR_W'(pos_q) + ADDR_W'(2);
    pos_d           = pos_q;
    playing_d       = playing_q;
    advance         = 1'b0;

    if (accept && sound_enable_q) begin
      if (action_i) begin
        // store the note (if the slot exists) and rewind to slot 0, idle
        ctrl.wr_en      = slot_in_range;
        ctrl.wr_freq_en = slot_in_range;
        ctrl.wr_addr    = POS_W'(slot_i);
        ctrl.wr_dur     = note_duration_i;
        ctrl.cur_sel    = CUR_MEM;
        ctrl.cur_addr   = '0;
        ctrl.nxt_sel    = NXT_MEM;
        ctrl.nxt_addr   = ADDR_W'(1);
        pos_d           = '0;
        playing_d       = 1'b0;
      end else if (playing_q) begin
        // count down in place
        ctrl.wr_en = 1'b1;
        if (dec_dur == '0) begin
          if (at_last || nxt_dur == '0) begin
            ctrl.cur_sel = CUR_ZERO;
            ctrl.nxt_sel = NXT_ZERO;
            pos_d        = '0;
            playing_d    = 1'b0;
          end else begin
            advance      = 1'b1;
            ctrl.cur_sel = CUR_NXT;
            ctrl.nxt_sel = NXT_MEM;
            pos_d        = pos_q + POS_W'(1);
          end
        end else begin
          ctrl.cur_sel = CUR_DEC;
        end
      end else if (cur_dur != '0) begin
        playing_d = 1'b1;
      end
    end

    res_d.speaker_on     = sound_enable_q && playing_d;
    res_d.tone_frequency = '0;
    if (sound_enable_q && playing_d) begin
      res_d.tone_frequency = advance ? nxt_freq : cur_freq;
    end
    res_d.play_position  = SLOT_W'(pos_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_enable_q <= 1'b1;
      pos_q          <= '0;
      playing_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sound_enable_q <= cfg_wdata_i;
      end
      pos_q     <= pos_d;
      playing_q <= playing_d;
    end
  end

  tts_note_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cur_dur_o  (cur_dur),
    .nxt_dur_o  (nxt_dur),
    .cur_freq_o (cur_freq),
    .nxt_freq_o (nxt_freq)
  );

  tts_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (res_q)
  );

  assign in_stall_o       = out_valid_o && out_stall_i;
  assign speaker_on_o     = res_q.speaker_on;
  assign tone_frequency_o = res_q.tone_frequency;
  assign play_position_o  = res_q.play_position;

  // a sounding slot always has ticks left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> cur_dur != '0)
    else $error("playing with an empty current slot");

  // idle playback always sits at slot 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> pos_q == '0)
    else $error("idle sequencer away from slot 0");

  // a note write with sound on always leaves the speaker silent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i && sound_enable_q
      |=> out_valid_o && !speaker_on_o && play_position_o == '0)
    else $error("note write did not silence playback");

  // a silent result carries no tone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !speaker_on_o |-> tone_frequency_o == '0)
    else $error("tone reported while silent");

  // disabled sound freezes playback state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sound_enable_q && !cfg_we_i |=> $stable(pos_q) && $stable(playing_q))
    else $error("playback moved while sound disabled");

endmodule

`default_nettype wire

/* rtl/core/tts_note_store.sv */
// ----------------------------------------------------------------------------
// tts_note_store
// Note memory (duration and frequency) with a two-entry read window:
// the current slot and the slot after it, both held in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_note_store (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tts_pkg::store_ctrl_t        ctrl_i,
  output logic [tts_pkg::DUR_W-1:0]        cur_dur_o,
  output logic [tts_pkg::DUR_W-1:0]        nxt_dur_o,
  output logic [tts_pkg::FREQ_W-1:0]       cur_freq_o,
  output logic [tts_pkg::FREQ_W-1:0]       nxt_freq_o
);
  import tts_pkg::*;

  logic [DUR_W-1:0]      dur_mem  [NOTE_SLOTS];
  logic [FREQ_W-1:0]     freq_mem [NOTE_SLOTS];
  logic [NOTE_SLOTS-1:0] valid_q;

  logic [DUR_W-1:0]  cur_dur_q, nxt_dur_q;
  logic [FREQ_W-1:0] cur_freq_q, nxt_freq_q;

  logic [POS_W-1:0] cur_idx, nxt_idx;
  logic             cur_in, nxt_in;
  logic             cur_hit, nxt_hit, cur_fhit, nxt_fhit;

  assign cur_idx  = ctrl_i.cur_addr[POS_W-1:0];
  assign nxt_idx  = ctrl_i.nxt_addr[POS_W-1:0];
  assign cur_in   = ctrl_i.cur_addr < ADDR_W'(NOTE_SLOTS);
  assign nxt_in   = ctrl_i.nxt_addr < ADDR_W'(NOTE_SLOTS);
  assign cur_hit  = ctrl_i.wr_en && ({1'b0, ctrl_i.wr_addr} == ctrl_i.cur_addr);
  assign nxt_hit  = ctrl_i.wr_en && ({1'b0, ctrl_i.wr_addr} == ctrl_i.nxt_addr);
  assign cur_fhit = ctrl_i.wr_freq_en && ({1'b0, ctrl_i.wr_addr} == ctrl_i.cur_addr);
  assign nxt_fhit = ctrl_i.wr_freq_en && ({1'b0, ctrl_i.wr_addr} == ctrl_i.nxt_addr);

  // durations reset to zero through the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      cur_dur_q <= '0;
      nxt_dur_q <= '0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[ctrl_i.wr_addr] <= 1'b1;
      end
      unique case (ctrl_i.cur_sel)
        CUR_MEM: begin
          if (cur_hit) begin
            cur_dur_q <= ctrl_i.wr_dur;
          end else if (cur_in && valid_q[cur_idx]) begin
            cur_dur_q <= dur_mem[cur_idx];
          end else begin
            cur_dur_q <= '0;
          end
        end
        CUR_NXT:  cur_dur_q <= nxt_dur_q;
        CUR_DEC:  cur_dur_q <= cur_dur_q - DUR_W'(1);
        CUR_ZERO: cur_dur_q <= '0;
        default: ;
      endcase
      unique case (ctrl_i.nxt_sel)
        NXT_MEM: begin
          if (nxt_hit) begin
            nxt_dur_q <= ctrl_i.wr_dur;
          end else if (nxt_in && valid_q[nxt_idx]) begin
            nxt_dur_q <= dur_mem[nxt_idx];
          end else begin
            nxt_dur_q <= '0;
          end
        end
        NXT_ZERO: nxt_dur_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      dur_mem[ctrl_i.wr_addr] <= ctrl_i.wr_dur;
    end
    if (ctrl_i.wr_freq_en) begin
      freq_mem[ctrl_i.wr_addr] <= ctrl_i.wr_freq;
    end
    unique case (ctrl_i.cur_sel)
      CUR_MEM: cur_freq_q <= cur_fhit ? ctrl_i.wr_freq : freq_mem[cur_idx];
      CUR_NXT: cur_freq_q <= nxt_freq_q;
      default: ;
    endcase
    unique case (ctrl_i.nxt_sel)
      NXT_MEM: nxt_freq_q <= nxt_fhit ? ctrl_i.wr_freq : freq_mem[nxt_idx];
      default: ;
    endcase
  end

  assign cur_dur_o  = cur_dur_q;
  assign nxt_dur_o  = nxt_dur_q;
  assign cur_freq_o = cur_freq_q;
  assign nxt_freq_o = nxt_freq_q;

endmodule

`default_nettype wire

/* rtl/core/tts_out_reg.sv */
// ----------------------------------------------------------------------------
// tts_out_reg
// Result register with valid/stall handshake toward the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire tts_pkg::result_t result_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output tts_pkg::result_t      result_o
);
  import tts_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    priority if (load_i) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

/* verif/tts_tb_pkg.sv */
// ----------------------------------------------------------------------------
// tts_tb_pkg
// Speaker-state tracker and result checker for the tone sequencer bench.
// ----------------------------------------------------------------------------
// Keeps its own note table, playback position and sound enable. Every input
// transfer becomes one expected speaker state. Output transfers are checked
// in order against those states.
package tts_tb_pkg;
  import tts_pkg::*;

  typedef enum bit {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  // keep a broken run from flooding the log
  localparam int MAX_REPORTS = 50;

  class speaker_tracker;
    bit [DUR_W-1:0]  dur_left [NOTE_SLOTS];
    bit [FREQ_W-1:0] tone_of  [NOTE_SLOTS];
    int unsigned     cur_slot;
    bit              sounding;
    bit              sound_on;
    result_t         speaker_due [$];
    int unsigned     errors, reports, results_seen;
    int unsigned     writes, ticks, muted, notes_started, songs_done;

    function new();
      sound_on = 1'b1;
    endfunction

    function void advance_tick();
      int unsigned nxt;
      if (sounding) begin
        // counting down is destructive: the melody is used up as it plays
        dur_left[cur_slot] = dur_left[cur_slot] - 1'b1;
        if (dur_left[cur_slot] == '0) begin
          nxt = cur_slot + 1;
          if (nxt >= NOTE_SLOTS || dur_left[nxt] == '0) begin
            sounding = 1'b0;
            nxt = 0;
            songs_done++;
          end else begin
            notes_started++;
          end
          cur_slot = nxt;
        end
      end else if (dur_left[cur_slot] != '0) begin
        sounding = 1'b1;
        notes_started++;
      end
    endfunction

    function void take_item(action_e act, logic [SLOT_W-1:0] slot,
                            logic [DUR_W-1:0] dur, logic [FREQ_W-1:0] freq);
      result_t due;
      due = '0;
      if (!sound_on) begin
        muted++;
      end else begin
        if (act == ACT_WRITE) begin
          writes++;
          if (slot < NOTE_SLOTS) begin
            dur_left[slot] = dur;
            tone_of[slot]  = freq;
          end
          cur_slot = 0;
          sounding = 1'b0;
        end else begin
          ticks++;
          advance_tick();
        end
        if (sounding) begin
          due.speaker_on     = 1'b1;
          due.tone_frequency = tone_of[cur_slot];
        end
      end
      due.play_position = cur_slot[SLOT_W-1:0];
      speaker_due.push_back(due);
    endfunction

    function void report(string field, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      end
    endfunction

    function void check_speaker(logic on, logic [FREQ_W-1:0] tone, logic [SLOT_W-1:0] pos);
      result_t due;
      results_seen++;
      if (speaker_due.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $error("output transfer with no result pending");
        end
        return;
      end
      due = speaker_due.pop_front();
      if (on !== due.speaker_on)
        report("speaker_on", FREQ_W'(due.speaker_on), FREQ_W'(on));
      if (tone !== due.tone_frequency)
        report("tone_frequency", due.tone_frequency, tone);
      if (pos !== due.play_position)
        report("play_position", FREQ_W'(due.play_position), FREQ_W'(pos));
    endfunction

    function void close_out();
      if (speaker_due.size() != 0) begin
        errors++;
        $error("%0d expected results never arrived", speaker_due.size());
      end
    endfunction
  endclass

endpackage

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and checking for the tick-driven tone sequencer.
// ----------------------------------------------------------------------------
// A short directed pass over the corner cases of playback, then random songs
// written into the note table and ticked through, mixed with stray writes,
// muted phases and output hold-offs. Both channels idle at random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;
  import tts_tb_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int TARGET_ITEMS  = 1600;
  localparam int IDLE_PCT      = 34;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              cfg_we_i         = 1'b0;
  logic              cfg_wdata_i      = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              action_i         = 1'b0;
  logic [SLOT_W-1:0] slot_i           = '0;
  logic [DUR_W-1:0]  note_duration_i  = '0;
  logic [FREQ_W-1:0] note_frequency_i = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic              speaker_on_o;
  logic [FREQ_W-1:0] tone_frequency_o;
  logic [SLOT_W-1:0] play_position_o;

  speaker_tracker tracker = new();
  bit             steady    = 1'b0;
  int unsigned    hold_left = 0;

  tick_driven_tone_sequencer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .slot_i           (slot_i),
    .note_duration_i  (note_duration_i),
    .note_frequency_i (note_frequency_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .speaker_on_o     (speaker_on_o),
    .tone_frequency_o (tone_frequency_o),
    .play_position_o  (play_position_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0)
        tracker.take_item(action_e'(action_i), slot_i, note_duration_i, note_frequency_i);
      if (out_valid_o === 1'b1 && !out_stall_i)
        tracker.check_speaker(speaker_on_o, tone_frequency_o, play_position_o);
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $error("no transfer for %0d cycles", QUIET_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // valid stays high from one transfer to the next unless idle cycles are inserted
  task automatic offer(action_e act, logic [SLOT_W-1:0] slot, logic [DUR_W-1:0] dur,
                       logic [FREQ_W-1:0] freq, bit back_to_back = 1'b0);
    if (!back_to_back && !steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    action_i         <= act;
    slot_i           <= slot;
    note_duration_i  <= dur;
    note_frequency_i <= freq;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // tick payload is don't-care, so it carries random bits
  task automatic timer_tick(bit back_to_back = 1'b0);
    offer(ACT_TICK, SLOT_W'($urandom_range(NOTE_SLOTS - 1, 0)),
          DUR_W'($urandom_range(255, 0)), FREQ_W'($urandom_range(16'hFFFF, 0)),
          back_to_back);
  endtask

  task automatic stray_items(int unsigned count);
    repeat (count)
      offer(action_e'($urandom_range(1, 0)), SLOT_W'($urandom_range(NOTE_SLOTS - 1, 0)),
            DUR_W'($urandom_range(255, 0)), FREQ_W'($urandom_range(16'hFFFF, 0)));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.speaker_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_sound(bit enable);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.sound_on = enable;
    @(posedge clk_i);
  endtask

  // output held off while input keeps coming, then drain completely
  task automatic hold_output(int unsigned cycles, int unsigned count);
    hold_left = cycles;
    repeat (count) timer_tick(1'b1);
    wait_idle();
  endtask

  function automatic logic [DUR_W-1:0] note_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2)
      return DUR_W'($urandom_range(255, 100));
    else if (roll < 12)
      return DUR_W'($urandom_range(20, 5));
    else
      return DUR_W'($urandom_range(4, 1));
  endfunction

  // write a melody from slot 0 up, close it with an empty slot unless it fills the table, tick it
  task automatic play_song();
    int unsigned len, total;
    logic [DUR_W-1:0] dur;
    case ($urandom_range(9))
      0:       len = NOTE_SLOTS;
      1, 2:    len = $urandom_range(NOTE_SLOTS - 1, 7);
      default: len = $urandom_range(6, 1);
    endcase
    total = 0;
    for (int i = 0; i < len; i++) begin
      dur = note_length();
      total += dur;
      offer(ACT_WRITE, i[SLOT_W-1:0], dur, FREQ_W'($urandom_range(16'hFFFF, 0)));
    end
    if (len < NOTE_SLOTS)
      offer(ACT_WRITE, len[SLOT_W-1:0], '0, FREQ_W'($urandom_range(16'hFFFF, 0)));
    // one tick to start, one per count, a few spare
    total += $urandom_range(3, 1);
    if ($urandom_range(4) == 0)
      total = $urandom_range(total, 1);
    repeat (total) begin
      if ($urandom_range(49) == 0)
        stray_items(1);
      else
        timer_tick();
    end
  endtask

  initial begin : stimulus
    int unsigned pick, done;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: ticks stay silent, tick payload at its extremes
    offer(ACT_TICK, '1, '1, '1);
    offer(ACT_TICK, '0, '0, '0);
    offer(ACT_WRITE, 5'd0, 8'd1, 16'hFFFF);
    offer(ACT_WRITE, 5'd1, 8'd2, 16'h0000);   // silent tone, but still sounding
    offer(ACT_WRITE, 5'd2, 8'd0, 16'h5A5A);   // end of song
    repeat (5) timer_tick();
    // write in the middle of a note drops back to slot 0, idle
    offer(ACT_WRITE, 5'd0, 8'd3, 16'h1234);
    repeat (2) timer_tick();
    offer(ACT_WRITE, 5'd31, 8'd255, 16'hFFFF);
    repeat (4) timer_tick();
    // muted in the middle of slot 1: position still shows, nothing changes
    offer(ACT_WRITE, 5'd1, 8'd3, 16'h8001);
    offer(ACT_WRITE, 5'd0, 8'd1, 16'h0001);
    repeat (2) timer_tick();
    set_sound(1'b0);
    timer_tick();
    offer(ACT_WRITE, 5'd0, 8'd9, 16'h4321);
    set_sound(1'b1);
    repeat (3) timer_tick();

    hold_output(80, 8);

    done = tracker.writes + tracker.ticks;
    while (done < TARGET_ITEMS) begin
      steady = (done >= 700 && done < 950);
      pick = $urandom_range(99);
      if (pick < 50) begin
        play_song();
      end else if (pick < 75) begin
        stray_items($urandom_range(8, 1));
      end else if (pick < 87) begin
        repeat ($urandom_range(10, 1)) timer_tick();
      end else if (pick < 93) begin
        set_sound(1'b0);
        stray_items($urandom_range(5, 1));
        set_sound(1'b1);
      end else if (pick < 97) begin
        hold_output($urandom_range(80, 40), 6);
      end else begin
        wait_idle();
      end
      done = tracker.writes + tracker.ticks;
    end
    steady = 1'b0;
    wait_idle();
    tracker.close_out();

    $display("ran %0d note writes, %0d ticks and %0d muted items",
             tracker.writes, tracker.ticks, tracker.muted);
    $display("%0d notes sounded, %0d songs ran out, %0d results compared, %0d mismatches",
             tracker.notes_started, tracker.songs_done, tracker.results_seen,
             tracker.errors);
    if (tracker.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tts_pkg.sv
rtl/core/tts_note_store.sv
rtl/core/tts_out_reg.sv
rtl/core/tick_driven_tone_sequencer.sv
verif/tts_tb_pkg.sv
verif/testbench.sv
